@@ hdl/fmb_pkg.sv @@
package fmb_pkg;

    localparam int MAX_ORBITALS = 16;
    localparam int LOG_N        = $clog2(MAX_ORBITALS);
    localparam int NW           = $clog2(MAX_ORBITALS + 1);
    localparam int MAT_AW       = 2 * LOG_N;
    localparam int CUBE_W       = 3 * LOG_N;
    localparam int INT_AW       = 4 * LOG_N;
    localparam int MAT_DEPTH    = MAX_ORBITALS * MAX_ORBITALS;
    localparam int INT_DEPTH    = MAT_DEPTH * MAT_DEPTH;

    localparam int MODE_W  = 3;
    localparam int IDX_W   = 16;
    localparam int VAL_W   = 48;
    localparam int ENTRY_W = 8;
    localparam int CFG_W   = 5;

    localparam logic [MODE_W-1:0] MODE_LD_CORE = 3'd0;
    localparam logic [MODE_W-1:0] MODE_LD_DENS = 3'd1;
    localparam logic [MODE_W-1:0] MODE_LD_INT  = 3'd2;
    localparam logic [MODE_W-1:0] MODE_COMPUTE = 3'd3;
    localparam logic [MODE_W-1:0] MODE_READ    = 3'd4;

    localparam logic KIND_ACK  = 1'b0;
    localparam logic KIND_DATA = 1'b1;

    localparam logic [CFG_W-1:0] CFG_RESET = 5'd16;

    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

    typedef enum logic [2:0] {
        OP_LD_CORE,
        OP_LD_DENS,
        OP_LD_INT,
        OP_COMPUTE,
        OP_READ
    } t_op;

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] index;
        logic [VAL_W-1:0] value;
        logic             rd_ok;
    } t_req;

    function automatic logic [NW-1:0] active_n(input logic [CFG_W-1:0] cfg);
        logic [NW-1:0] n;
        if (cfg == '0) begin
            n = NW'(1);
        end else if (32'(cfg) > MAX_ORBITALS) begin
            n = NW'(MAX_ORBITALS);
        end else begin
            n = NW'(cfg);
        end
        return n;
    endfunction

endpackage

@@ hdl/fmb_in_if.sv @@
interface fmb_in_if import fmb_pkg::*;;
    logic              valid;
    logic              ready;
    logic [MODE_W-1:0] mode;
    logic [IDX_W-1:0]  index;
    logic [VAL_W-1:0]  value;

    modport source (output valid, output mode, output index, output value, input ready);
    modport sink   (input valid, input mode, input index, input value, output ready);
endinterface

@@ hdl/fmb_out_if.sv @@
interface fmb_out_if import fmb_pkg::*;;
    logic               valid;
    logic               ready;
    logic               kind;
    logic [ENTRY_W-1:0] entry_index;
    logic [VAL_W-1:0]   fock_value;

    modport source (output valid, output kind, output entry_index, output fock_value,
                    input ready);
    modport sink   (input valid, input kind, input entry_index, input fock_value,
                    output ready);
endinterface

@@ hdl/fock_matrix_build_core.sv @@
// channel | dir | handshake     | payload
// i_in    | in  | valid/ready   | mode, index, value
// o_out   | out | valid/ready   | kind, entry_index, fock_value
// i_cfg   | in  | wr_en         | wr_data (orbitals in use)
//
// Loads are written as they leave the queue; unused modes and out-of-range loads drop at the queue.
// A read passes S_RDW and S_RDO on its way to the output register; S_RDO waits while the output is full.
// Compute is paced by a 4-pass partial-product multiplier
// and the single read port of the integral RAM.
// A two-entry queue decouples input from the back end; output is registered.
// Synchronous active-low reset clears control; memories are undefined until loaded.
module fock_matrix_build_core import fmb_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_wr_en,
    input  logic [CFG_W-1:0] i_cfg_wr_data,
    fmb_in_if.sink           i_in,
    fmb_out_if.source        o_out
);
    logic [CFG_W-1:0] r_orbitals;
    logic [NW-1:0]    n_active;
    logic             q_valid, q_pop;
    t_req             q_req;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_orbitals <= CFG_RESET;
        end else if (i_cfg_wr_en) begin
            r_orbitals <= i_cfg_wr_data;
        end
    end

    assign n_active = active_n(r_orbitals);

    fmb_front u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_n(n_active), .i_in(i_in),
        .o_q_valid(q_valid), .o_q_req(q_req), .i_q_pop(q_pop));

    fmb_back u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_n(n_active),
        .i_q_valid(q_valid), .i_q_req(q_req), .o_q_pop(q_pop), .o_out(o_out));
endmodule

@@ hdl/fmb_ram.sv @@
module fmb_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

@@ hdl/fmb_front.sv @@
module fmb_front import fmb_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [NW-1:0] i_n,
    fmb_in_if.sink        i_in,
    output logic          o_q_valid,
    output t_req          o_q_req,
    input  logic          i_q_pop
);
    t_req       r_fifo [2];
    logic       r_wptr, r_rptr;
    logic [1:0] r_count;
    t_req       n_req;
    logic       n_keep;
    logic       push;

    always_comb begin
        n_req.index = i_in.index;
        n_req.value = i_in.value;
        n_req.rd_ok = 32'(i_in.index) < 32'(i_n) * 32'(i_n);
        n_req.op    = OP_READ;
        n_keep      = 1'b1;
        case (i_in.mode)
            MODE_LD_CORE: begin
                n_req.op = OP_LD_CORE;
                n_keep   = 32'(i_in.index) < MAT_DEPTH;
            end
            MODE_LD_DENS: begin
                n_req.op = OP_LD_DENS;
                n_keep   = 32'(i_in.index) < MAT_DEPTH;
            end
            MODE_LD_INT: begin
                n_req.op = OP_LD_INT;
                n_keep   = 32'(i_in.index) < INT_DEPTH;
            end
            MODE_COMPUTE: n_req.op = OP_COMPUTE;
            MODE_READ:    n_req.op = OP_READ;
            default:      n_keep   = 1'b0;
        endcase
    end

    assign i_in.ready = r_count != 2'd2;
    assign push       = i_in.valid && i_in.ready && n_keep;
    assign o_q_valid  = r_count != 2'd0;
    assign o_q_req    = r_fifo[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_fifo[r_wptr] <= n_req;
        end
        if (!i_rst_n) begin
            r_wptr  <= 1'b0;
            r_rptr  <= 1'b0;
            r_count <= 2'd0;
        end else begin
            if (push) begin
                r_wptr <= ~r_wptr;
            end
            if (i_q_pop) begin
                r_rptr <= ~r_rptr;
            end
            r_count <= r_count + 2'(push) - 2'(i_q_pop);
        end
    end
endmodule

@@ hdl/fmb_back.sv @@
module fmb_back import fmb_pkg::*; (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic [NW-1:0] i_n,
    input  logic          i_q_valid,
    input  t_req          i_q_req,
    output logic          o_q_pop,
    fmb_out_if.source     o_out
);
    typedef enum logic [4:0] {
        S_IDLE, S_RDW, S_RDO, S_PQ, S_CORE0, S_CORE1, S_ADR0, S_ADR1, S_ADR2,
        S_RD0, S_RD1, S_RD2, S_MUL, S_RND, S_ACC, S_WR, S_ACK
    } t_state;

    t_state              r_state;
    logic [NW-1:0]       r_n;
    logic [LOG_N-1:0]    r_p, r_q, r_r, r_s;
    logic [MAT_AW-1:0]   r_pq, r_pr, r_rs;
    logic [CUBE_W-1:0]   r_c1, r_e1;
    logic [INT_AW-1:0]   r_ca, r_ea;
    logic [VAL_W-1:0]    r_coul, r_dens;
    logic [VAL_W:0]      r_ma;
    logic [VAL_W-1:0]    r_mb;
    logic                r_neg;
    logic [1:0]          r_k;
    logic [96:0]         r_prod;
    logic signed [VAL_W-1:0] r_term, r_acc, r_fdata;
    logic                r_out_valid, r_kind;
    logic [ENTRY_W-1:0]  r_entry;
    logic [VAL_W-1:0]    r_value;
    logic [IDX_W-1:0]    r_idx;
    logic                r_rd_ok;

    logic [VAL_W-1:0]    core_rd, dens_rd, int_rd, fock_rd;
    logic                core_we, dens_we, int_we, fock_we;
    logic [INT_AW-1:0]   int_raddr;
    logic                out_free;
    logic [LOG_N-1:0]    last;
    logic [31:0]         mx, my;
    logic [63:0]         pp;
    logic [6:0]          sh;
    logic [VAL_W:0]      diff;
    logic [96:0]         rnd;
    logic [64:0]         qv;
    logic signed [VAL_W:0] sum;

    assign out_free = !r_out_valid || o_out.ready;
    assign last     = LOG_N'(r_n - NW'(1));
    assign o_q_pop  = (r_state == S_IDLE) && i_q_valid;

    assign core_we   = o_q_pop && i_q_req.op == OP_LD_CORE;
    assign dens_we   = o_q_pop && i_q_req.op == OP_LD_DENS;
    assign int_we    = o_q_pop && i_q_req.op == OP_LD_INT;
    assign fock_we   = r_state == S_WR;
    assign int_raddr = (r_state == S_RD1) ? r_ea : r_ca;

    fmb_ram #(.WIDTH(VAL_W), .DEPTH(MAT_DEPTH)) u_core (
        .i_clk(i_clk), .i_we(core_we), .i_waddr(MAT_AW'(i_q_req.index)),
        .i_wdata(i_q_req.value), .i_raddr(r_pq), .o_rdata(core_rd));
    fmb_ram #(.WIDTH(VAL_W), .DEPTH(MAT_DEPTH)) u_dens (
        .i_clk(i_clk), .i_we(dens_we), .i_waddr(MAT_AW'(i_q_req.index)),
        .i_wdata(i_q_req.value), .i_raddr(r_rs), .o_rdata(dens_rd));
    fmb_ram #(.WIDTH(VAL_W), .DEPTH(INT_DEPTH)) u_int (
        .i_clk(i_clk), .i_we(int_we), .i_waddr(INT_AW'(i_q_req.index)),
        .i_wdata(i_q_req.value), .i_raddr(int_raddr), .o_rdata(int_rd));
    fmb_ram #(.WIDTH(VAL_W), .DEPTH(MAT_DEPTH)) u_fock (
        .i_clk(i_clk), .i_we(fock_we), .i_waddr(r_pq), .i_wdata(r_acc),
        .i_raddr(MAT_AW'(i_q_req.index)), .o_rdata(fock_rd));

    // partial products of |diff| * |density|
    always_comb begin
        case (r_k)
            2'd0: begin mx = r_ma[31:0];         my = r_mb[31:0];         sh = 7'd0;  end
            2'd1: begin mx = r_ma[31:0];         my = 32'(r_mb[47:32]);   sh = 7'd32; end
            2'd2: begin mx = 32'(r_ma[48:32]);   my = r_mb[31:0];         sh = 7'd32; end
            default: begin mx = 32'(r_ma[48:32]); my = 32'(r_mb[47:32]); sh = 7'd64; end
        endcase
        pp   = mx * my;
        diff = {r_coul[VAL_W-1], r_coul} - {int_rd[VAL_W-1], int_rd};
        rnd  = r_prod + 97'(64'h8000_0000);
        qv   = rnd[96:32];
        sum  = {r_acc[VAL_W-1], r_acc} + {r_term[VAL_W-1], r_term};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    r_idx   <= i_q_req.index;
                    r_rd_ok <= i_q_req.rd_ok;
                    if (i_q_valid) begin
                        if (i_q_req.op == OP_READ) begin
                            r_state <= S_RDW;
                        end else if (i_q_req.op == OP_COMPUTE) begin
                            r_n     <= i_n;
                            r_p     <= '0;
                            r_q     <= '0;
                            r_state <= S_PQ;
                        end
                    end
                end
                S_RDW: begin
                    r_fdata <= r_rd_ok ? fock_rd : '0;
                    r_state <= S_RDO;
                end
                S_RDO: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_kind      <= KIND_DATA;
                        r_entry     <= r_idx[ENTRY_W-1:0];
                        r_value     <= r_fdata;
                        r_state     <= S_IDLE;
                    end
                end
                S_PQ: begin
                    r_pq    <= MAT_AW'(r_p) * MAT_AW'(r_n) + MAT_AW'(r_q);
                    r_state <= S_CORE0;
                end
                S_CORE0: r_state <= S_CORE1;
                S_CORE1: begin
                    r_acc   <= core_rd;
                    r_r     <= '0;
                    r_s     <= '0;
                    r_state <= S_ADR0;
                end
                S_ADR0: begin
                    r_pr    <= MAT_AW'(r_p) * MAT_AW'(r_n) + MAT_AW'(r_r);
                    r_rs    <= MAT_AW'(r_r) * MAT_AW'(r_n) + MAT_AW'(r_s);
                    r_state <= S_ADR1;
                end
                S_ADR1: begin
                    r_c1    <= CUBE_W'(r_pq) * CUBE_W'(r_n) + CUBE_W'(r_r);
                    r_e1    <= CUBE_W'(r_pr) * CUBE_W'(r_n) + CUBE_W'(r_q);
                    r_state <= S_ADR2;
                end
                S_ADR2: begin
                    r_ca    <= INT_AW'(r_c1) * INT_AW'(r_n) + INT_AW'(r_s);
                    r_ea    <= INT_AW'(r_e1) * INT_AW'(r_n) + INT_AW'(r_s);
                    r_state <= S_RD0;
                end
                S_RD0: r_state <= S_RD1;
                S_RD1: begin
                    r_coul  <= int_rd;
                    r_dens  <= dens_rd;
                    r_state <= S_RD2;
                end
                S_RD2: begin
                    r_ma    <= diff[VAL_W] ? -diff : diff;
                    r_mb    <= r_dens[VAL_W-1] ? -r_dens : r_dens;
                    r_neg   <= diff[VAL_W] ^ r_dens[VAL_W-1];
                    r_prod  <= '0;
                    r_k     <= '0;
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_prod <= r_prod + (97'(pp) << sh);
                    r_k    <= r_k + 2'd1;
                    if (r_k == 2'd3) begin
                        r_state <= S_RND;
                    end
                end
                S_RND: begin
                    if (r_neg) begin
                        r_term <= (qv >= 65'h8000_0000_0000) ? VAL_MIN
                                                             : -VAL_W'(qv);
                    end else begin
                        r_term <= (qv > 65'h7FFF_FFFF_FFFF) ? VAL_MAX : VAL_W'(qv);
                    end
                    r_state <= S_ACC;
                end
                S_ACC: begin
                    if (sum[VAL_W] != sum[VAL_W-1]) begin
                        r_acc <= sum[VAL_W] ? VAL_MIN : VAL_MAX;
                    end else begin
                        r_acc <= sum[VAL_W-1:0];
                    end
                    r_state <= S_ADR0;
                    r_s     <= r_s + LOG_N'(1);
                    if (r_s == last) begin
                        r_s <= '0;
                        r_r <= r_r + LOG_N'(1);
                        if (r_r == last) begin
                            r_state <= S_WR;
                        end
                    end
                end
                S_WR: begin
                    r_state <= S_PQ;
                    r_q     <= r_q + LOG_N'(1);
                    if (r_q == last) begin
                        r_q <= '0;
                        r_p <= r_p + LOG_N'(1);
                        if (r_p == last) begin
                            r_state <= S_ACK;
                        end
                    end
                end
                S_ACK: begin
                    if (out_free) begin
                        r_out_valid <= 1'b1;
                        r_kind      <= KIND_ACK;
                        r_entry     <= '0;
                        r_value     <= '0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.kind        = r_kind;
    assign o_out.entry_index = r_entry;
    assign o_out.fock_value  = r_value;
endmodule

@@ hdl/fmb_checker.sv @@
module fmb_checker import fmb_pkg::*; (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_in_ready,
    input logic               i_out_valid,
    input logic               i_out_ready,
    input logic               i_out_kind,
    input logic [ENTRY_W-1:0] i_out_entry,
    input logic [VAL_W-1:0]   i_out_value
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_out_value))
        else $error("result dropped while stalled");

    a_rst_out: assert property (@(posedge i_clk) !i_rst_n |=> !i_out_valid)
        else $error("result valid after reset");

    a_rst_ready: assert property (@(posedge i_clk) !i_rst_n |=> i_in_ready)
        else $error("input not ready after reset");

    a_ack_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_out_kind == KIND_ACK |-> i_out_entry == '0 && i_out_value == '0)
        else $error("acknowledge carries data");
endmodule

bind fock_matrix_build_core fmb_checker u_fmb_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_ready(i_in.ready),
    .i_out_valid(o_out.valid), .i_out_ready(o_out.ready), .i_out_kind(o_out.kind),
    .i_out_entry(o_out.entry_index), .i_out_value(o_out.fock_value));
